// ----- rtl/core/tccw_pkg.sv -----
`timescale 1ns / 1ps

package tccw_pkg;

  // Default geometry of the text screen.
  localparam int COLUMNS_DEFAULT   = 80;
  localparam int ROWS_DEFAULT      = 25;
  localparam int TAB_WIDTH_DEFAULT = 8;

  localparam int CELL_W = 16;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // Command codes.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SWEEP,
    ST_READ,
    ST_RESPOND
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic home;
    logic put;
    logic sweep;
    logic read;
    logic respond;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic scroll;
  } ctl_stat_t;

endpackage

// ----- rtl/core/text_console_char_writer.sv -----
`timescale 1ns / 1ps

// Text console of COLUMNS x ROWS 16-bit cells (attribute in the high byte,
// character in the low byte) with a cursor. Raise start for one cycle with
// busy low to hand over an item; each item produces exactly one result, shown
// for a single cycle with done high, and the receiver cannot hold it off.
// After reset the block is busy while it blanks every cell. A put that
// moves the cursor below the last row also scrolls the screen: the scroll
// walks the single-write, single-read cell memory once, one cell per cycle.
module text_console_char_writer
  import tccw_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEFAULT,
  parameter int ROWS      = ROWS_DEFAULT,
  parameter int TAB_WIDTH = TAB_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_code,
  input  logic [3:0]  back_colour,
  input  logic [3:0]  fore_colour,
  input  logic [10:0] cell_address,
  output logic        done,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row_out,
  output logic [10:0] cursor_location,
  output logic [15:0] read_data
);

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  tccw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  tccw_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .cmd             (cmd),
    .char_code       (char_code),
    .back_colour     (back_colour),
    .fore_colour     (fore_colour),
    .cell_address    (cell_address),
    .stat            (stat),
    .done            (done),
    .cursor_col      (cursor_col),
    .cursor_row_out  (cursor_row_out),
    .cursor_location (cursor_location),
    .read_data       (read_data)
  );

endmodule

// ----- rtl/core/tccw_ctrl.sv -----
`timescale 1ns / 1ps

module tccw_ctrl
  import tccw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [1:0] cmd,
  input  ctl_stat_t stat,
  output logic      busy,
  output ctl_cmd_t  ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_PUT:   state_next = ST_PUT;
            CMD_CLEAR: state_next = ST_SWEEP;
            CMD_READ:  state_next = ST_READ;
            default:   state_next = ST_RESPOND;
          endcase
        end
      end
      ST_PUT: begin
        state_next = stat.scroll ? ST_SWEEP : ST_RESPOND;
      end
      ST_SWEEP: begin
        if (stat.sweep_last) begin
          state_next = ST_RESPOND;
        end
      end
      ST_READ: begin
        state_next = ST_RESPOND;
      end
      ST_RESPOND: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = (state != ST_IDLE);
    ctl.latch   = (state == ST_IDLE) && start;
    ctl.home    = (state == ST_IDLE) && start && (cmd == CMD_CLEAR);
    ctl.put     = (state == ST_PUT);
    ctl.sweep   = (state == ST_INIT) || (state == ST_SWEEP);
    ctl.read    = (state == ST_READ);
    ctl.respond = (state == ST_RESPOND);
  end

endmodule

// ----- rtl/core/tccw_datapath.sv -----
`timescale 1ns / 1ps

module tccw_datapath
  import tccw_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEFAULT,
  parameter int ROWS      = ROWS_DEFAULT,
  parameter int TAB_WIDTH = TAB_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    ctl,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_code,
  input  logic [3:0]  back_colour,
  input  logic [3:0]  fore_colour,
  input  logic [10:0] cell_address,
  output ctl_stat_t   stat,
  output logic        done,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row_out,
  output logic [10:0] cursor_location,
  output logic [15:0] read_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int AP_W       = ADDR_W + 1;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int PH_W       = $clog2(TAB_WIDTH);
  localparam int NC_W       = $clog2(COLUMNS + TAB_WIDTH);
  localparam int COLX_W     = (COL_W > 7) ? COL_W : 7;
  localparam int ROWX_W     = (ROW_W > 5) ? ROW_W : 5;
  localparam int LOCX_W     = (ADDR_W > 11) ? ADDR_W : 11;
  localparam int CMP_W      = LOCX_W + 1;

  // Latched item.
  logic [1:0]  cmd_r;
  logic [7:0]  char_r;
  logic [3:0]  back_r;
  logic [3:0]  fore_r;
  logic [10:0] addr_r;

  // Cursor, with the column modulo the tab width kept alongside it.
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [PH_W-1:0]  ph;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [PH_W-1:0]  ph_next;

  logic [NC_W-1:0]   col_adv;
  logic [PH_W-1:0]   ph_adv;
  logic              go_down;
  logic              printable;
  logic              scroll;
  logic [ADDR_W-1:0] cell_index;

  // Sweep engine: one cell per cycle, read in copy mode; its write follows in the next cycle.
  logic [ADDR_W-1:0] ptr;
  logic              copy_mode;
  logic              st_en;
  logic [ADDR_W-1:0] st_addr;
  logic              st_blank;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              put_we;

  logic [LOCX_W-1:0] addr_x;
  logic              in_range;
  logic [COLX_W-1:0] col_x;
  logic [ROWX_W-1:0] row_x;
  logic [LOCX_W-1:0] loc_x;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r  <= cmd;
      char_r <= char_code;
      back_r <= back_colour;
      fore_r <= fore_colour;
      addr_r <= cell_address;
    end
  end

  assign cell_index = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);

  always_comb begin
    printable = char_r inside {[CH_PRINT_LO:CH_PRINT_HI]};
    col_adv   = NC_W'(col);
    ph_adv    = ph;
    go_down   = 1'b0;
    case (char_r)
      CH_BS: begin
        if (col != '0) begin
          col_adv = NC_W'(col) - NC_W'(1);
          ph_adv  = (ph == '0) ? PH_W'(TAB_WIDTH - 1) : ph - PH_W'(1);
        end
      end
      CH_TAB: begin
        col_adv = NC_W'(col) + NC_W'(TAB_WIDTH) - NC_W'(ph);
        ph_adv  = '0;
      end
      CH_CR: begin
        col_adv = '0;
        ph_adv  = '0;
      end
      CH_LF: begin
        col_adv = '0;
        ph_adv  = '0;
        go_down = 1'b1;
      end
      default: begin
        if (printable) begin
          col_adv = NC_W'(col) + NC_W'(1);
          ph_adv  = (ph == PH_W'(TAB_WIDTH - 1)) ? '0 : ph + PH_W'(1);
        end
      end
    endcase

    // Past the last column the cursor wraps to the start of the next row.
    if (col_adv >= NC_W'(COLUMNS)) begin
      col_adv = '0;
      ph_adv  = '0;
      go_down = 1'b1;
    end

    col_next = COL_W'(col_adv);
    ph_next  = ph_adv;
    scroll   = go_down && (row == ROW_W'(ROWS - 1));
    row_next = (go_down && !scroll) ? row + ROW_W'(1) : row;
  end

  assign stat.scroll     = scroll;
  assign stat.sweep_last = (ptr == ADDR_W'(CELL_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      ph        <= '0;
      ptr       <= '0;
      copy_mode <= 1'b0;
      st_en     <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (ctl.home) begin
        col <= '0;
        row <= '0;
        ph  <= '0;
      end else if (ctl.put) begin
        col <= col_next;
        row <= row_next;
        ph  <= ph_next;
      end
      if (ctl.put) begin
        copy_mode <= 1'b1;
      end else if (ctl.latch) begin
        copy_mode <= 1'b0;
      end
      ptr   <= ctl.sweep ? ptr + ADDR_W'(1) : '0;
      st_en <= ctl.sweep;
      done  <= ctl.respond;
    end
  end

  always_ff @(posedge clk) begin
    st_addr  <= ptr;
    st_blank <= !copy_mode || (ptr >= ADDR_W'(COPY_COUNT));
  end

  assign addr_x   = LOCX_W'(addr_r);
  assign in_range = CMP_W'(addr_r) < CMP_W'(CELL_COUNT);

  always_comb begin
    put_we = ctl.put && printable;
    we     = put_we || st_en;
    if (put_we) begin
      waddr = cell_index;
      wdata = {back_r, fore_r, char_r};
    end else begin
      waddr = st_addr;
      wdata = st_blank ? BLANK_CELL : rdata;
    end
    if (ctl.read) begin
      re    = in_range;
      raddr = addr_x[ADDR_W-1:0];
    end else begin
      re    = ctl.sweep && copy_mode && (ptr < ADDR_W'(COPY_COUNT));
      raddr = ptr + ADDR_W'(COLUMNS);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign col_x = COLX_W'(col);
  assign row_x = ROWX_W'(row);
  assign loc_x = LOCX_W'(cell_index);

  always_ff @(posedge clk) begin
    if (ctl.respond) begin
      cursor_col      <= col_x[6:0];
      cursor_row_out  <= row_x[4:0];
      cursor_location <= loc_x[10:0];
      read_data       <= ((cmd_r == CMD_READ) && in_range) ? rdata : '0;
    end
  end

`ifndef SYNTH
  // A character store and a pending sweep write would share the one write port.
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(ctl.put && st_en))
    else $error("character store collides with a sweep write");

  a_cursor_in_screen: assert property (@(posedge clk) disable iff (rst)
    (col < COL_W'(COLUMNS)) && ({1'b0, row} < (ROW_W + 1)'(ROWS)))
    else $error("cursor left the screen");

  a_sweep_write_in_range: assert property (@(posedge clk) disable iff (rst)
    st_en |-> ({1'b0, st_addr} < AP_W'(CELL_COUNT)))
    else $error("sweep write beyond the last cell");

  a_scroll_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    (ctl.put && scroll) |=> ctl.sweep && (ptr == '0))
    else $error("scroll did not start a sweep from the first cell");
`endif

endmodule
